/* src/gbn_pkg.sv */
// ----------------------------------------------------------------------------
// gbn_pkg
// Shared widths, register indexes and the neighbour offset tables of the
// grid bucket neighbourhood block.
// ----------------------------------------------------------------------------
package gbn_pkg;

  // Field and register widths
  localparam int unsigned COORD_W          = 24;
  localparam int unsigned AXIS_W           = 9;
  localparam int unsigned REM_W            = 13;
  localparam int unsigned CELL_W           = 16;
  localparam int unsigned SLOT_W           = 4;
  localparam int unsigned DIV_BITS_PER_STG = 4;
  localparam int unsigned CFG_IDX_W        = 2;
  localparam int unsigned CFG_DATA_W       = 13;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CELLS_X   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CELLS_Y   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CELL_SIZE = 2'd2;

  // Position of a row or column index relative to the grid edges
  typedef enum logic [1:0] {
    EDGE_FIRST = 2'd0,
    EDGE_MID   = 2'd1,
    EDGE_LAST  = 2'd2
  } edge_e;

  // Neighbourhood class: row class * 3 + column class
  typedef logic [3:0] nb_cls_t;

  // Offsets plus one, packed as {row[1:0], col[1:0]}, per class and slot
  localparam logic [3:0] NB_OFF [9][9] = '{
    '{4'h5, 4'h6, 4'h9, 4'hA, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0},
    '{4'h4, 4'h5, 4'h6, 4'h8, 4'h9, 4'hA, 4'h0, 4'h0, 4'h0},
    '{4'h4, 4'h5, 4'h8, 4'h9, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0},
    '{4'h1, 4'h5, 4'h9, 4'h2, 4'h6, 4'hA, 4'h0, 4'h0, 4'h0},
    '{4'h0, 4'h1, 4'h2, 4'h4, 4'h5, 4'h6, 4'h8, 4'h9, 4'hA},
    '{4'h0, 4'h4, 4'h8, 4'h1, 4'h5, 4'h9, 4'h0, 4'h0, 4'h0},
    '{4'h1, 4'h2, 4'h5, 4'h6, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0},
    '{4'h0, 4'h1, 4'h2, 4'h4, 4'h5, 4'h6, 4'h0, 4'h0, 4'h0},
    '{4'h0, 4'h1, 4'h4, 4'h5, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0}
  };

  localparam logic [SLOT_W-1:0] NB_CNT [9] = '{
    4'd4, 4'd6, 4'd4, 4'd6, 4'd9, 4'd6, 4'd4, 4'd6, 4'd4
  };

  function automatic nb_cls_t nb_class(edge_e rc, edge_e cc);
    logic [3:0] r;
    logic [3:0] c;
    r = 4'(rc);
    c = 4'(cc);
    return 4'(r * 4'd3 + c);
  endfunction

  function automatic logic [SLOT_W-1:0] nb_count(nb_cls_t cls);
    if (cls > 4'd8) begin
      return '0;
    end
    return NB_CNT[cls];
  endfunction

  function automatic logic [3:0] nb_offset(nb_cls_t cls, logic [SLOT_W-1:0] k);
    if (cls > 4'd8 || k > 4'd8) begin
      return 4'h5;
    end
    return NB_OFF[cls][k];
  endfunction

endpackage

/* src/gbn_div_stage.sv */
// ----------------------------------------------------------------------------
// gbn_div_stage
// One register stage of the pipelined restoring divider: retires STEPS
// quotient bits for both axes against the shared divisor.
// ----------------------------------------------------------------------------
module gbn_div_stage import gbn_pkg::*; #(
  parameter int unsigned DVD_W = 16,
  parameter int unsigned STEPS = 4
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [REM_W-1:0]            divisor_i,
  input  logic                        valid_i,
  output logic                        ready_o,
  input  logic [1:0][REM_W-1:0]       rem_i,
  input  logic [1:0][DVD_W-1:0]       dvd_i,
  output logic                        valid_o,
  input  logic                        ready_i,
  output logic [1:0][REM_W-1:0]       rem_o,
  output logic [1:0][DVD_W-1:0]       dvd_o
);

  logic                  valid_q;
  logic                  load;
  logic [1:0][REM_W-1:0] rem_d, rem_q;
  logic [1:0][DVD_W-1:0] dvd_d, dvd_q;

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;

  // Restoring division steps; quotient bits shift in from the bottom
  always_comb begin
    logic [REM_W:0]   t;
    logic [REM_W-1:0] r;
    logic [DVD_W-1:0] q;
    for (int a = 0; a < 2; a++) begin
      r = rem_i[a];
      q = dvd_i[a];
      for (int s = 0; s < STEPS; s++) begin
        t = {r, q[DVD_W-1]};
        q = q << 1;
        if (t >= {1'b0, divisor_i}) begin
          r    = REM_W'(t - {1'b0, divisor_i});
          q[0] = 1'b1;
        end else begin
          r = t[REM_W-1:0];
        end
      end
      rem_d[a] = r;
      dvd_d[a] = q;
    end
  end

  // Stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Stage payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      rem_q <= rem_d;
      dvd_q <= dvd_d;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign dvd_o   = dvd_q;

endmodule

/* src/grid_bucket_neighbourhood.sv */
// ----------------------------------------------------------------------------
// grid_bucket_neighbourhood
// Maps a fixed-point shape centre to its grid cell and lists the cells of
// the clipped 3x3 neighbourhood, one result per transfer.
// ----------------------------------------------------------------------------
// Each input transfer yields 9, 6 or 4 results (interior, edge, corner cell)
// or a single result flagged outside, on one result channel at one result
// per cycle while out_ready_i stays high; the input side keeps accepting
// until the stages in front of the result sequencer are full. Cell row and
// column come from a pipelined restoring divider that retires four quotient
// bits per stage, ceil((24 - COORD_FRACTION_BITS) / 4) stages (4 at
// defaults), followed by a classify/multiply stage, a home-index stage, the
// result sequencer and the output register. Configuration is written
// through the cfg channel, which is always ready.
module grid_bucket_neighbourhood import gbn_pkg::*; #(
  parameter int unsigned MAX_CELLS_PER_AXIS  = 256,
  parameter int unsigned COORD_FRACTION_BITS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // input items
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [COORD_W-1:0]    centre_x_i,
  input  logic [COORD_W-1:0]    centre_y_i,
  // results
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [CELL_W-1:0]     home_cell_o,
  output logic [CELL_W-1:0]     neighbour_cell_o,
  output logic [SLOT_W-1:0]     slot_o,
  output logic [SLOT_W-1:0]     neighbour_count_o,
  output logic                  outside_o,
  output logic                  last_o
);

  localparam int unsigned DIV_W    = COORD_W - COORD_FRACTION_BITS;
  localparam int unsigned NUM_STG  = (DIV_W + DIV_BITS_PER_STG - 1) / DIV_BITS_PER_STG;
  localparam int unsigned DVD_W    = NUM_STG * DIV_BITS_PER_STG;
  localparam int unsigned CMP_W    = (DVD_W > AXIS_W) ? DVD_W : AXIS_W;
  localparam int unsigned AXIS_LIM = (1 << AXIS_W) - 1;
  localparam int unsigned AXIS_MAX = (MAX_CELLS_PER_AXIS < AXIS_LIM) ?
                                     MAX_CELLS_PER_AXIS : AXIS_LIM;
  localparam logic [AXIS_W-1:0] AXIS_MAX_V = AXIS_W'(AXIS_MAX);
  localparam logic [AXIS_W-1:0] AXIS_MIN_V = AXIS_W'(2);
  localparam int unsigned PROD_W   = 2 * AXIS_W;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [AXIS_W-1:0] cells_x_q, cells_y_q;
  logic [REM_W-1:0]  cell_size_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cells_x_q   <= AXIS_W'(2);
      cells_y_q   <= AXIS_W'(2);
      cell_size_q <= REM_W'(1);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_CELLS_X:   cells_x_q   <= cfg_data_i[AXIS_W-1:0];
        CFG_CELLS_Y:   cells_y_q   <= cfg_data_i[AXIS_W-1:0];
        CFG_CELL_SIZE: cell_size_q <= cfg_data_i[REM_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective grid size and divisor
  logic [AXIS_W-1:0] nx, ny;
  logic [REM_W-1:0]  divisor;

  assign nx = (cells_x_q < AXIS_MIN_V) ? AXIS_MIN_V :
              (cells_x_q > AXIS_MAX_V) ? AXIS_MAX_V : cells_x_q;
  assign ny = (cells_y_q < AXIS_MIN_V) ? AXIS_MIN_V :
              (cells_y_q > AXIS_MAX_V) ? AXIS_MAX_V : cells_y_q;
  assign divisor = (cell_size_q == '0) ? REM_W'(1) : cell_size_q;

  // --------------------------------------------------------------------------
  // Divider pipeline: whole pixels divided by the cell size, both axes
  // --------------------------------------------------------------------------
  logic [NUM_STG:0]                  stg_valid;
  logic [NUM_STG:0]                  stg_ready;
  logic [NUM_STG:0][1:0][REM_W-1:0]  stg_rem;
  logic [NUM_STG:0][1:0][DVD_W-1:0]  stg_dvd;

  assign stg_valid[0]  = in_valid_i;
  assign in_ready_o    = stg_ready[0];
  assign stg_rem[0]    = '0;
  assign stg_dvd[0][0] = DVD_W'(centre_x_i >> COORD_FRACTION_BITS);
  assign stg_dvd[0][1] = DVD_W'(centre_y_i >> COORD_FRACTION_BITS);

  for (genvar g = 0; g < NUM_STG; g++) begin : g_div
    gbn_div_stage #(
      .DVD_W (DVD_W),
      .STEPS (DIV_BITS_PER_STG)
    ) u_stage (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .divisor_i (divisor),
      .valid_i   (stg_valid[g]),
      .ready_o   (stg_ready[g]),
      .rem_i     (stg_rem[g]),
      .dvd_i     (stg_dvd[g]),
      .valid_o   (stg_valid[g+1]),
      .ready_i   (stg_ready[g+1]),
      .rem_o     (stg_rem[g+1]),
      .dvd_o     (stg_dvd[g+1])
    );
  end

  // --------------------------------------------------------------------------
  // Classify stage: range check, edge classes, row times stride
  // --------------------------------------------------------------------------
  logic [CMP_W-1:0]  qx, qy;
  logic [AXIS_W-1:0] row_i, col_j;
  logic              c_outside_d;
  edge_e             c_rc_d, c_cc_d;
  logic [PROD_W-1:0] c_prod_d;

  logic              c_valid_q, c_ready;
  logic              c_outside_q;
  edge_e             c_rc_q, c_cc_q;
  logic [PROD_W-1:0] c_prod_q;
  logic [AXIS_W-1:0] c_col_q;

  // downstream stage handshakes
  logic              h_ready, em_take;

  always_comb begin
    qx          = CMP_W'(stg_dvd[NUM_STG][0]);
    qy          = CMP_W'(stg_dvd[NUM_STG][1]);
    row_i       = AXIS_W'(qx);
    col_j       = AXIS_W'(qy);
    c_outside_d = (qx >= CMP_W'(nx)) || (qy >= CMP_W'(ny));
    c_rc_d      = (row_i == '0) ? EDGE_FIRST :
                  (row_i == nx - AXIS_W'(1)) ? EDGE_LAST : EDGE_MID;
    c_cc_d      = (col_j == '0) ? EDGE_FIRST :
                  (col_j == ny - AXIS_W'(1)) ? EDGE_LAST : EDGE_MID;
    c_prod_d    = {{AXIS_W{1'b0}}, ny} * {{AXIS_W{1'b0}}, row_i};
  end

  assign c_ready            = !c_valid_q || h_ready;
  assign stg_ready[NUM_STG] = c_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
    end else if (c_ready) begin
      c_valid_q <= stg_valid[NUM_STG];
    end
  end

  always_ff @(posedge clk_i) begin
    if (c_ready && stg_valid[NUM_STG]) begin
      c_outside_q <= c_outside_d;
      c_rc_q      <= c_rc_d;
      c_cc_q      <= c_cc_d;
      c_prod_q    <= c_prod_d;
      c_col_q     <= col_j;
    end
  end

  // --------------------------------------------------------------------------
  // Home stage: home index and neighbourhood class
  // --------------------------------------------------------------------------
  logic              h_valid_q;
  logic              h_outside_q;
  logic [CELL_W-1:0] h_home_q;
  nb_cls_t           h_cls_q;

  assign h_ready = !h_valid_q || em_take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_valid_q <= 1'b0;
    end else if (h_ready) begin
      h_valid_q <= c_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (h_ready && c_valid_q) begin
      h_outside_q <= c_outside_q;
      h_home_q    <= CELL_W'(c_prod_q + PROD_W'(c_col_q));
      h_cls_q     <= nb_class(c_rc_q, c_cc_q);
    end
  end

  // --------------------------------------------------------------------------
  // Result sequencer: walks the slots of one item into the output register
  // --------------------------------------------------------------------------
  logic              em_valid_q;
  logic              em_outside_q;
  logic [CELL_W-1:0] em_home_q;
  nb_cls_t           em_cls_q;
  logic [SLOT_W-1:0] em_cnt_q;
  logic [SLOT_W-1:0] em_slot_d, em_slot_q;
  logic              em_last, out_load;

  logic              out_valid_q;

  assign out_load = em_valid_q && (!out_valid_q || out_ready_i);
  assign em_last  = em_outside_q || (em_slot_q == em_cnt_q - SLOT_W'(1));
  assign em_take  = !em_valid_q || (out_load && em_last);

  always_comb begin
    em_slot_d = em_slot_q;
    if (em_take) begin
      em_slot_d = '0;
    end else if (out_load) begin
      em_slot_d = em_slot_q + SLOT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      em_valid_q <= 1'b0;
      em_slot_q  <= '0;
    end else begin
      if (em_take) begin
        em_valid_q <= h_valid_q;
      end
      em_slot_q <= em_slot_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (em_take && h_valid_q) begin
      em_outside_q <= h_outside_q;
      em_home_q    <= h_home_q;
      em_cls_q     <= h_cls_q;
      em_cnt_q     <= h_outside_q ? '0 : nb_count(h_cls_q);
    end
  end

  // Neighbour index: home plus/minus one row stride, plus column offset
  logic [3:0]        nb_off;
  logic [1:0]        dr, dc;
  logic [CELL_W-1:0] stride, row_base, nb_cell;

  always_comb begin
    nb_off = nb_offset(em_cls_q, em_slot_q);
    dr     = nb_off[3:2];
    dc     = nb_off[1:0];
    stride = CELL_W'(ny);
    case (dr)
      2'd0:    row_base = em_home_q - stride;
      2'd2:    row_base = em_home_q + stride;
      default: row_base = em_home_q;
    endcase
    nb_cell = row_base + CELL_W'(dc) - CELL_W'(1);
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  logic [CELL_W-1:0] home_q, cell_q;
  logic [SLOT_W-1:0] slot_q, count_q;
  logic              outside_q, last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      home_q    <= em_outside_q ? '0 : em_home_q;
      cell_q    <= em_outside_q ? '0 : nb_cell;
      slot_q    <= em_outside_q ? '0 : em_slot_q;
      count_q   <= em_cnt_q;
      outside_q <= em_outside_q;
      last_q    <= em_last;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign home_cell_o       = home_q;
  assign neighbour_cell_o  = cell_q;
  assign slot_o            = slot_q;
  assign neighbour_count_o = count_q;
  assign outside_o         = outside_q;
  assign last_o            = last_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // An in-grid result always lies inside its list
  a_slot_in_list: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !outside_o |-> slot_o < neighbour_count_o)
    else $error("slot beyond neighbour count");

  // An outside result is a lone, empty, final result
  a_outside_lone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && outside_o |-> last_o && neighbour_count_o == '0 && slot_o == '0)
    else $error("outside result not single and empty");

  // After a non-final transfer the next slot follows at once
  a_slot_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_o |=>
      out_valid_o && slot_o == $past(slot_o) + SLOT_W'(1))
    else $error("slot sequence broken");

  // Only 4, 6 or 9 neighbours for a cell inside the grid
  a_count_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    em_valid_q && !em_outside_q |->
      em_cnt_q == SLOT_W'(4) || em_cnt_q == SLOT_W'(6) || em_cnt_q == SLOT_W'(9))
    else $error("illegal neighbour count");

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for grid_bucket_neighbourhood. Centres are driven over
// the input handshake, a scoreboard predicts the clipped 3x3 neighbour list
// of each accepted centre, and every result transfer is checked in order.
// ----------------------------------------------------------------------------
module tb import gbn_pkg::*; ();

  localparam int FRAC_BITS = 8;
  localparam int MAX_AXIS  = 256;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  // One result of the neighbour list
  typedef struct packed {
    logic [CELL_W-1:0] home;
    logic [CELL_W-1:0] nb_cell;
    logic [SLOT_W-1:0] slot;
    logic [SLOT_W-1:0] count;
    logic              outside;
    logic              last;
  } nb_result_t;

  // Predicts neighbour lists from the register copy and checks results
  class neighbour_board;
    int unsigned axis_x_reg = 2;
    int unsigned axis_y_reg = 2;
    int unsigned size_reg   = 1;
    nb_result_t  awaited_cells[$];
    int          mismatches = 0;

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_CELLS_X:   axis_x_reg = 32'(data[AXIS_W-1:0]);
        CFG_CELLS_Y:   axis_y_reg = 32'(data[AXIS_W-1:0]);
        CFG_CELL_SIZE: size_reg   = 32'(data);
        default: ;
      endcase
    endfunction

    function int clamp_axis(int unsigned raw);
      if (raw < 2) return 2;
      if (raw > MAX_AXIS) return MAX_AXIS;
      return raw;
    endfunction

    function int rows();
      return clamp_axis(axis_x_reg);
    endfunction

    function int cols();
      return clamp_axis(axis_y_reg);
    endfunction

    function int divisor();
      return ((size_reg == 0) ? 1 : size_reg) << FRAC_BITS;
    endfunction

    // Works out the neighbour list of one accepted centre
    function void note_centre(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
      int nx, ny, dv, row, col, r, c, n;
      bit col_major;
      nb_result_t res;
      nb_result_t nb_list[$];
      nx  = rows();
      ny  = cols();
      dv  = divisor();
      row = x / dv;
      col = y / dv;
      res = '0;
      if (row >= nx || col >= ny) begin
        res.outside = 1'b1;
        res.last    = 1'b1;
        awaited_cells = {awaited_cells, res};
        return;
      end
      // interior rows on a left/right edge list column by column,
      // everything else lists row by row
      col_major = (row != 0 && row != nx - 1) && (col == 0 || col == ny - 1);
      for (int a = -1; a <= 1; a++) begin
        for (int b = -1; b <= 1; b++) begin
          r = col_major ? row + b : row + a;
          c = col_major ? col + a : col + b;
          if (r >= 0 && r < nx && c >= 0 && c < ny) begin
            res.home    = CELL_W'(ny * row + col);
            res.nb_cell = CELL_W'(ny * r + c);
            nb_list = {nb_list, res};
          end
        end
      end
      n = nb_list.size();
      foreach (nb_list[k]) begin
        res       = nb_list[k];
        res.slot  = SLOT_W'(k);
        res.count = SLOT_W'(n);
        res.last  = (k == n - 1);
        awaited_cells = {awaited_cells, res};
      end
    endfunction

    function void compare_field(string fname, int unsigned want, int unsigned got);
      if (want != got) begin
        mismatches++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
      end
    endfunction

    // Checks one result transfer against the oldest prediction
    function void check_cell(nb_result_t got);
      nb_result_t want;
      if (awaited_cells.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, actual home %0d cell %0d",
                 $time, got.home, got.nb_cell);
        return;
      end
      want = awaited_cells.pop_front();
      compare_field("home_cell", 32'(want.home), 32'(got.home));
      compare_field("neighbour_cell", 32'(want.nb_cell), 32'(got.nb_cell));
      compare_field("slot", 32'(want.slot), 32'(got.slot));
      compare_field("neighbour_count", 32'(want.count), 32'(got.count));
      compare_field("outside", 32'(want.outside), 32'(got.outside));
      compare_field("last", 32'(want.last), 32'(got.last));
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic [COORD_W-1:0]    centre_x_i;
  logic [COORD_W-1:0]    centre_y_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic [CELL_W-1:0]     home_cell_o;
  logic [CELL_W-1:0]     neighbour_cell_o;
  logic [SLOT_W-1:0]     slot_o;
  logic [SLOT_W-1:0]     neighbour_count_o;
  logic                  outside_o;
  logic                  last_o;

  bit             steady = 1'b0;
  neighbour_board sb = new();

  grid_bucket_neighbourhood uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .centre_x_i        (centre_x_i),
    .centre_y_i        (centre_y_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .home_cell_o       (home_cell_o),
    .neighbour_cell_o  (neighbour_cell_o),
    .slot_o            (slot_o),
    .neighbour_count_o (neighbour_count_o),
    .outside_o         (outside_o),
    .last_o            (last_o)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Run limit
  initial begin
    #5ms;
    $display("Test completed with failures");
    $finish;
  end

  // Receiver: random back-pressure except during the steady stretch
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      out_ready_i = steady ? 1'b1 : ($urandom_range(0, 99) >= 32);
    end
  end

  // Result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_cell('{home_cell_o, neighbour_cell_o, slot_o, neighbour_count_o,
                      outside_o, last_o});
    end
  end

  // Coordinate somewhere inside cell k, or random when k is out of reach
  function automatic logic [COORD_W-1:0] place(int k, int dv);
    longint v;
    v = longint'(k) * dv + $urandom_range(0, dv - 1);
    if (v > 24'hFFFFFF) return COORD_W'($urandom);
    return COORD_W'(v);
  endfunction

  // Cell index along one axis, biased toward the edges and just beyond
  function automatic int pick_axis(int n);
    int s;
    s = $urandom_range(0, 9);
    if (s < 2) return 0;
    if (s < 4) return n - 1;
    if (s == 4) return n;
    return $urandom_range(0, n - 1);
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, data);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic send_centre(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
    while (!steady && $urandom_range(0, 99) < 32) @(negedge clk_i);
    in_valid_i = 1'b1;
    centre_x_i = x;
    centre_y_i = y;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_centre(x, y);
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic send_cell(input int row, input int col);
    send_centre(place(row, sb.divisor()), place(col, sb.divisor()));
  endtask

  // Hold off until every predicted result is out and the pipe is empty
  task automatic wait_drained();
    while (sb.awaited_cells.size() != 0) @(negedge clk_i);
    repeat (12) @(negedge clk_i);
  endtask

  task automatic set_grid(input logic [CFG_DATA_W-1:0] nx, input logic [CFG_DATA_W-1:0] ny,
                          input logic [CFG_DATA_W-1:0] size);
    wait_drained();
    write_reg(CFG_CELLS_X, nx);
    write_reg(CFG_CELLS_Y, ny);
    write_reg(CFG_CELL_SIZE, size);
  endtask

  // Mostly well-formed centres near edges, about a fifth raw noise
  task automatic send_random(input int count);
    repeat (count) begin
      if ($urandom_range(0, 99) < 20) begin
        send_centre(COORD_W'($urandom), COORD_W'($urandom));
      end else begin
        send_cell(pick_axis(sb.rows()), pick_axis(sb.cols()));
      end
    end
  endtask

  // Main sequence
  initial begin
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    centre_x_i  = '0;
    centre_y_i  = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);

    // reset grid 2x2, cell size 1: corners, fraction truncation, beyond grid
    send_centre(24'h000000, 24'h000000);
    send_centre(24'h0001FF, 24'h0001FF);
    send_centre(24'h0001FF, 24'h000000);
    send_centre(24'h000000, 24'h000100);
    send_centre(24'hFFFFFF, 24'hFFFFFF);
    send_centre(24'h000000, 24'h000200);  // column past the edge must not wrap
    send_centre(24'h000200, 24'h000000);

    // 5x4 grid: every edge class but the first-row, first-column corner
    set_grid(13'd5, 13'd4, 13'd2);
    send_cell(0, 2);
    send_cell(2, 0);
    send_cell(2, 2);
    send_cell(2, 3);
    send_cell(4, 1);
    send_cell(4, 3);
    send_cell(0, 3);
    send_cell(4, 0);
    send_cell(1, 1);

    // largest grid: top index
    set_grid(13'd256, 13'd256, 13'd1);
    send_cell(255, 255);
    send_cell(128, 200);
    send_centre(24'hFFFFFF, 24'h000000);

    // axis sizes below range and zero cell size
    set_grid(13'd0, 13'd1, 13'd0);
    send_random(20);

    // all register bits set: axes clamp high, oversized cell
    set_grid(13'h1FFF, 13'h1FFF, 13'h1FFF);
    write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
    send_random(20);

    // no idling on either side
    set_grid(13'd12, 13'd9, 13'd5);
    steady = 1'b1;
    send_random(50);
    wait_drained();
    steady = 1'b0;

    set_grid(13'd256, 13'd256, 13'd4096);
    send_random(20);

    set_grid(13'd3, 13'd300, 13'd1);
    send_random(20);

    repeat (4) begin
      set_grid(CFG_DATA_W'($urandom_range(2, 20)), CFG_DATA_W'($urandom_range(2, 20)),
               CFG_DATA_W'($urandom_range(1, 64)));
      send_random(20);
    end

    wait_drained();
    repeat (20) @(negedge clk_i);
    if (sb.mismatches == 0 && sb.awaited_cells.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* grid_bucket_neighbourhood.f */
src/gbn_pkg.sv
src/gbn_div_stage.sv
src/grid_bucket_neighbourhood.sv
tb/tb.sv
